@@ sv/session_slot_table_lru_assert.svh @@
// Assertion macros used by the session slot table controller.
// Needs clk and arst_n in scope at each point of use.
`ifndef SESSION_SLOT_TABLE_LRU_ASSERT_SVH
`define SESSION_SLOT_TABLE_LRU_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ssl_pkg.sv @@
// Shared types and constants of the session slot table.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssl_pkg;

	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned IDX_W_DEF = 4;
	localparam int unsigned CNT_W_DEF = 5;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned SLOT_W    = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd8;

	// slot states
	localparam logic [1:0] ST_NONE        = 2'd0;
	localparam logic [1:0] ST_HANDSHAKING = 2'd1;
	localparam logic [1:0] ST_ACTIVE      = 2'd2;

	// operations
	localparam logic [1:0] FN_LOOKUP   = 2'd0;
	localparam logic [1:0] FN_ALLOC    = 2'd1;
	localparam logic [1:0] FN_TEARDOWN = 2'd2;
	localparam logic [1:0] FN_UPDATE   = 2'd3;

	// result status
	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_CAP  = 2'd2;
	localparam logic [1:0] STS_FULL = 2'd3;

	typedef enum logic [1:0] {
		WR_CLAIM,
		WR_FREE,
		WR_UPDATE
	} wr_kind_t;

	// write broadcast from the controller to every cell
	typedef struct packed {
		logic        en;
		wr_kind_t    kind;
		logic [1:0]  state;
		logic        ver;
		logic [31:0] peer;
		logic [31:0] stamp;
	} wr_cmd_t;

	// fixed-width part of the scan token handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic        hit;
		logic [1:0]  hit_state;
		logic        hit_ver;
		logic        free_found;
		logic        vic_found;
		logic [31:0] vic_time;
	} tok_fix_t;

endpackage

`default_nettype wire

@@ sv/ssl_cell.sv @@
// One slot of the session table plus its stage of the scan chain.
// Depends on ssl_pkg.
`default_nettype none

module ssl_cell #(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned IDX_W    = ssl_pkg::IDX_W_DEF,
	parameter int unsigned CNT_W    = ssl_pkg::CNT_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ssl_pkg::tok_fix_t tok_in,
	input  logic [IDX_W-1:0]  hit_idx_in,
	input  logic [CNT_W-1:0]  hs_cnt_in,
	input  logic [IDX_W-1:0]  free_idx_in,
	input  logic [IDX_W-1:0]  vic_idx_in,
	output ssl_pkg::tok_fix_t tok_out,
	output logic [IDX_W-1:0]  hit_idx_out,
	output logic [CNT_W-1:0]  hs_cnt_out,
	output logic [IDX_W-1:0]  free_idx_out,
	output logic [IDX_W-1:0]  vic_idx_out,
	input  ssl_pkg::wr_cmd_t  wr,
	input  logic [IDX_W-1:0]  wr_idx
);
	import ssl_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [1:0]  st_q;
	logic        ver_q;
	logic [31:0] peer_q;
	logic [31:0] last_q;

	tok_fix_t         tok_d, tok_q;
	logic [IDX_W-1:0] hit_idx_d, free_idx_d, vic_idx_d;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic [CNT_W-1:0] hs_cnt_d, hs_cnt_q;
	logic             match, evictable, wr_me;

	assign match     = (st_q != ST_NONE) && (peer_q == tok_in.addr);
	assign evictable = (st_q != ST_NONE) && !((st_q == ST_ACTIVE) && ver_q);
	assign wr_me     = wr.en && (wr_idx == MY_IDX);

	always_comb begin
		tok_d      = tok_in;
		hit_idx_d  = hit_idx_in;
		free_idx_d = free_idx_in;
		vic_idx_d  = vic_idx_in;
		hs_cnt_d   = hs_cnt_in + CNT_W'(st_q == ST_HANDSHAKING);
		if (!tok_in.hit && match) begin
			tok_d.hit       = 1'b1;
			tok_d.hit_state = st_q;
			tok_d.hit_ver   = ver_q;
			hit_idx_d       = MY_IDX;
		end
		if (!tok_in.free_found && (st_q == ST_NONE)) begin
			tok_d.free_found = 1'b1;
			free_idx_d       = MY_IDX;
		end
		// strict less-than keeps ties at the lower index
		if (evictable && (!tok_in.vic_found || (last_q < tok_in.vic_time))) begin
			tok_d.vic_found = 1'b1;
			tok_d.vic_time  = last_q;
			vic_idx_d       = MY_IDX;
		end
	end

	// slot control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_NONE;
			ver_q <= 1'b0;
		end else if (wr_me) begin
			case (wr.kind)
				WR_CLAIM: begin
					st_q  <= ST_HANDSHAKING;
					ver_q <= 1'b0;
				end
				WR_FREE: begin
					st_q  <= ST_NONE;
					ver_q <= 1'b0;
				end
				WR_UPDATE: begin
					st_q  <= wr.state;
					ver_q <= wr.ver;
				end
				default: begin
					st_q  <= st_q;
				end
			endcase
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (wr_me && (wr.kind == WR_CLAIM)) begin
			peer_q <= wr.peer;
		end
		if (wr_me && ((wr.kind == WR_CLAIM) || (wr.kind == WR_UPDATE))) begin
			last_q <= wr.stamp;
		end
	end

	// scan stage: advance the token, hold payload when no token passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.valid) begin
			tok_q <= tok_d;
		end else begin
			tok_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			hit_idx_q  <= hit_idx_d;
			free_idx_q <= free_idx_d;
			vic_idx_q  <= vic_idx_d;
			hs_cnt_q   <= hs_cnt_d;
		end
	end

	assign tok_out      = tok_q;
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;
	assign vic_idx_out  = vic_idx_q;
	assign hs_cnt_out   = hs_cnt_q;

endmodule

`default_nettype wire

@@ sv/ssl_ctrl.sv @@
// Request sequencer of the session table: launches the scan token,
// decides on its return, broadcasts the write and holds the result.
// Depends on ssl_pkg and session_slot_table_lru_assert.svh.
`default_nettype none
`include "session_slot_table_lru_assert.svh"

module ssl_ctrl #(
	parameter int unsigned IDX_W = ssl_pkg::IDX_W_DEF,
	parameter int unsigned CNT_W = ssl_pkg::CNT_W_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [31:0]                remote_addr,
	input  logic [31:0]                now_ms,
	input  logic [1:0]                 new_state,
	input  logic                       new_verified,
	input  logic [ssl_pkg::CAP_W-1:0]  cap,
	output ssl_pkg::tok_fix_t          inj,
	input  ssl_pkg::tok_fix_t          fin,
	input  logic [IDX_W-1:0]           fin_hit_idx,
	input  logic [CNT_W-1:0]           fin_hs_cnt,
	input  logic [IDX_W-1:0]           fin_free_idx,
	input  logic [IDX_W-1:0]           fin_vic_idx,
	output ssl_pkg::wr_cmd_t           wr,
	output logic [IDX_W-1:0]           wr_idx,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [ssl_pkg::SLOT_W-1:0] slot,
	output logic [1:0]                 slot_state,
	output logic                       slot_verified
);
	import ssl_pkg::*;

	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [1:0]        func_q, nst_q;
	logic              nver_q;
	logic [31:0]       now_q;
	tok_fix_t          inj_q;
	logic              out_valid_q;
	logic [1:0]        status_q, slot_state_q;
	logic [SLOT_W-1:0] slot_q;
	logic              slot_verified_q;

	logic             go, cap_hit;
	logic [1:0]       nst_sat, res_status, res_state;
	logic             res_ver;
	logic [IDX_W-1:0] res_idx;
	wr_cmd_t          wr_d;

	assign go       = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign nst_sat  = (nst_q > ST_ACTIVE) ? ST_ACTIVE : nst_q;
	assign cap_hit  = CMP_W'(fin_hs_cnt) >= CMP_W'(cap);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		res_status = STS_OK;
		res_idx    = fin_hit_idx;
		res_state  = fin.hit_state;
		res_ver    = fin.hit_ver;
		wr_d       = '{en: 1'b0, kind: WR_CLAIM, state: ST_HANDSHAKING, ver: 1'b0,
			peer: fin.addr, stamp: now_q};
		case (func_q)
			FN_LOOKUP: begin
				if (!fin.hit) res_status = STS_MISS;
			end
			FN_TEARDOWN: begin
				if (fin.hit) begin
					wr_d.en   = 1'b1;
					wr_d.kind = WR_FREE;
					res_state = ST_NONE;
					res_ver   = 1'b0;
				end else begin
					res_status = STS_MISS;
				end
			end
			FN_UPDATE: begin
				if (fin.hit) begin
					wr_d.en    = 1'b1;
					wr_d.kind  = WR_UPDATE;
					wr_d.state = nst_sat;
					wr_d.ver   = nver_q;
					res_state  = nst_sat;
					res_ver    = nver_q;
				end else begin
					res_status = STS_MISS;
				end
			end
			FN_ALLOC: begin
				if (fin.hit) begin
					res_status = STS_OK;
				end else if (cap_hit) begin
					res_status = STS_CAP;
				end else if (fin.free_found || fin.vic_found) begin
					wr_d.en   = 1'b1;
					res_idx   = fin.free_found ? fin_free_idx : fin_vic_idx;
					res_state = ST_HANDSHAKING;
					res_ver   = 1'b0;
				end else begin
					res_status = STS_FULL;
				end
			end
			default: begin
				res_status = STS_MISS;
			end
		endcase
	end

	always_comb begin
		wr    = wr_d;
		wr.en = wr_d.en && go;
	end
	assign wr_idx = res_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			func_q          <= FN_LOOKUP;
			nst_q           <= ST_NONE;
			nver_q          <= 1'b0;
			now_q           <= '0;
			inj_q           <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= STS_OK;
			slot_q          <= '0;
			slot_state_q    <= ST_NONE;
			slot_verified_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						now_q   <= now_ms;
						nst_q   <= new_state;
						nver_q  <= new_verified;
						inj_q   <= '{valid: 1'b1, addr: remote_addr, default: '0};
						state_q <= S_SCAN;
					end else begin
						inj_q.valid <= 1'b0;
					end
				end
				S_SCAN: begin
					inj_q.valid <= 1'b0;
					if (fin.valid) state_q <= S_DONE;
				end
				S_DONE: begin
					if (go) state_q <= S_IDLE;
				end
				default: begin
					inj_q.valid <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase

			if (go) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				if (res_status == STS_OK) begin
					slot_q          <= SLOT_W'(res_idx);
					slot_state_q    <= res_state;
					slot_verified_q <= res_ver;
				end else begin
					slot_q          <= '0;
					slot_state_q    <= ST_NONE;
					slot_verified_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign inj           = inj_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign slot_state    = slot_state_q;
	assign slot_verified = slot_verified_q;

	`SSL_ASSERT_NOW(a_wr_only_done, wr.en, state_q == S_DONE, "table write outside decision")
	`SSL_ASSERT_NOW(a_fin_in_scan, fin.valid, state_q == S_SCAN, "scan token returned unexpectedly")
	`SSL_ASSERT_NEXT(a_accept_launch, in_valid && in_ready, inj_q.valid, "no token after transfer")
	`SSL_ASSERT_NEXT(a_go_result, go, out_valid_q, "decision without result")
	`SSL_ASSERT_NOW(a_fail_zero, out_valid_q && (status_q != STS_OK),
		(slot_q == '0) && (slot_state_q == ST_NONE) && !slot_verified_q,
		"failed request carries slot data")

endmodule

`default_nettype wire

@@ sv/session_slot_table_lru.sv @@
// Top level of the peer-session slot table with LRU eviction.
// Depends on ssl_pkg, ssl_cell and ssl_ctrl.
//
//   channel   handshake              payload
//   --------  ---------------------  -------------------------------------------
//   request   in_valid / in_ready    func, remote_addr, now_ms, new_state,
//                                    new_verified
//   result    out_valid / out_ready  status, slot, slot_state, slot_verified
//   config    cfg_wr_en (no wait)    cfg_wr_data = handshake_cap
//
// One request is in flight at a time: the controller registers the scan token at
// launch, the token walks the chain of SLOTS cells, one cell per cycle, and the
// controller then decides on its return and registers the result.
// A stalled result stalls the decision, so in_ready stays low until it drains.
// Reset frees every slot, clears the verified flags and sets the cap to 8.
`default_nettype none

module session_slot_table_lru #(
	parameter int unsigned SLOTS = ssl_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ssl_pkg::CAP_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [31:0]                remote_addr,
	input  logic [31:0]                now_ms,
	input  logic [1:0]                 new_state,
	input  logic                       new_verified,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [ssl_pkg::SLOT_W-1:0] slot,
	output logic [1:0]                 slot_state,
	output logic                       slot_verified
);
	import ssl_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	// handshake cap register; the user writes it only while the table is idle, the block does not enforce this
	logic [CAP_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// scan chain: position 0 is the launch point, position SLOTS the return
	tok_fix_t         tok      [SLOTS+1];
	logic [IDX_W-1:0] hit_idx  [SLOTS+1];
	logic [CNT_W-1:0] hs_cnt   [SLOTS+1];
	logic [IDX_W-1:0] free_idx [SLOTS+1];
	logic [IDX_W-1:0] vic_idx  [SLOTS+1];

	wr_cmd_t          wr;
	logic [IDX_W-1:0] wr_idx;

	// the token starts empty: no hit, no handshaking slot seen, no candidate
	assign hit_idx[0]  = '0;
	assign hs_cnt[0]   = '0;
	assign free_idx[0] = '0;
	assign vic_idx[0]  = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		ssl_cell #(
			.CELL_IDX (g),
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_in       (tok[g]),
			.hit_idx_in   (hit_idx[g]),
			.hs_cnt_in    (hs_cnt[g]),
			.free_idx_in  (free_idx[g]),
			.vic_idx_in   (vic_idx[g]),
			.tok_out      (tok[g+1]),
			.hit_idx_out  (hit_idx[g+1]),
			.hs_cnt_out   (hs_cnt[g+1]),
			.free_idx_out (free_idx[g+1]),
			.vic_idx_out  (vic_idx[g+1]),
			.wr           (wr),
			.wr_idx       (wr_idx)
		);
	end

	// launch the token, decide on its return, broadcast the write, hold the result
	ssl_ctrl #(
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.remote_addr   (remote_addr),
		.now_ms        (now_ms),
		.new_state     (new_state),
		.new_verified  (new_verified),
		.cap           (cap_q),
		.inj           (tok[0]),
		.fin           (tok[SLOTS]),
		.fin_hit_idx   (hit_idx[SLOTS]),
		.fin_hs_cnt    (hs_cnt[SLOTS]),
		.fin_free_idx  (free_idx[SLOTS]),
		.fin_vic_idx   (vic_idx[SLOTS]),
		.wr            (wr),
		.wr_idx        (wr_idx),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot          (slot),
		.slot_state    (slot_state),
		.slot_verified (slot_verified)
	);

endmodule

`default_nettype wire

@@ bench/session_slot_table_lru_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the session slot table: a directed script, then random traffic.
// Every result is checked against an in-bench model of the table. Needs ssl_pkg and the RTL.

module session_slot_table_lru_test;

	import ssl_pkg::*;

	localparam int NSLOT  = SLOTS_DEF;
	localparam int POOL_N = 24;        // more peers than slots, so alloc has to evict
	localparam int NROWS  = 24;
	localparam int RANDOM_ITEMS = 1800;
	localparam int LIMIT  = 400000;    // cycles; the watchdog fails the run at this count

	// new_state value that lies outside the defined states and must saturate to active
	localparam logic [1:0] ST_OVER = 2'd3;
	localparam logic [CAP_W-1:0] NO_CAP = '0;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] addr;
		logic [31:0] now;
		logic [1:0]  nst;
		logic        nver;
	} slot_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        state;
		logic              ver;
	} slot_res_t;

	typedef enum logic { ROW_REQ, ROW_CAP } row_kind_t;
	typedef enum logic { WANT_MODEL, WANT_TYPED } want_src_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CAP_W-1:0] cap;
		slot_req_t        req;
		want_src_t        src;
		slot_res_t        want;
	} script_row_t;

	typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_BEAT, RX_HOLD } rx_mode_t;

	// DUT connections; every input starts at a known value
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]  cfg_wr_data = CAP_RESET;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        func = FN_LOOKUP;
	logic [31:0]       remote_addr = '0;
	logic [31:0]       now_ms = '0;
	logic [1:0]        new_state = ST_NONE;
	logic              new_verified = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [1:0]        slot_state;
	logic              slot_verified;

	// bench copy of the table and its register
	logic [1:0]       tbl_state [NSLOT];
	logic [31:0]      tbl_peer  [NSLOT];
	logic             tbl_ver   [NSLOT];
	logic [31:0]      tbl_seen  [NSLOT];
	logic [CAP_W-1:0] cap_model = CAP_RESET;

	slot_res_t   outcome_due [$];  // results owed by the block, oldest first
	logic [31:0] peer_pool [POOL_N];
	logic [31:0] clock_ms = '0;
	int          cyc = 0;
	int          mismatch_cnt = 0;
	int          random_sent = 0;
	int          burst_left = 0;
	int          steady = 0;       // nonzero: the sender puts no gap between bursts in this phase
	int          rx_hold = 0;

	// Directed script. Rows marked WANT_TYPED carry their result by hand; the rest
	// are predicted. The table walks through hit, miss, saturation, free-by-update
	// and the cap extremes.
	script_row_t script [NROWS] = '{
		// empty table: every search misses
		'{ROW_REQ, NO_CAP, '{FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_MISS, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_TEARDOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OVER, 1'b1},
			WANT_TYPED, '{STS_MISS, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_UPDATE, 32'h1234_5678, 32'h0000_0001, ST_ACTIVE, 1'b1},
			WANT_TYPED, '{STS_MISS, 4'd0, ST_NONE, 1'b0}},
		// fill the two lowest slots at the address and time extremes
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'h0000_0000, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_OK, 4'd0, ST_HANDSHAKING, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OVER, 1'b1},
			WANT_TYPED, '{STS_OK, 4'd1, ST_HANDSHAKING, 1'b0}},
		// alloc of a present peer hands back the slot as it is
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'h0000_0000, 32'h0000_0009, ST_ACTIVE, 1'b1},
			WANT_TYPED, '{STS_OK, 4'd0, ST_HANDSHAKING, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_OK, 4'd1, ST_HANDSHAKING, 1'b0}},
		// state 3 saturates to active
		'{ROW_REQ, NO_CAP, '{FN_UPDATE, 32'hFFFF_FFFF, 32'h0000_0005, ST_OVER, 1'b1},
			WANT_TYPED, '{STS_OK, 4'd1, ST_ACTIVE, 1'b1}},
		'{ROW_REQ, NO_CAP, '{FN_UPDATE, 32'h0000_0000, 32'h0000_0006, ST_ACTIVE, 1'b0},
			WANT_MODEL, '0},
		// update to none frees the slot but reports the stored flag
		'{ROW_REQ, NO_CAP, '{FN_UPDATE, 32'h0000_0000, 32'h0000_0006, ST_NONE, 1'b1},
			WANT_TYPED, '{STS_OK, 4'd0, ST_NONE, 1'b1}},
		'{ROW_REQ, NO_CAP, '{FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_MISS, 4'd0, ST_NONE, 1'b0}},
		// reuse of that slot clears the flag
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'hA5A5_A5A5, 32'h0000_0007, ST_NONE, 1'b1},
			WANT_TYPED, '{STS_OK, 4'd0, ST_HANDSHAKING, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_TEARDOWN, 32'hA5A5_A5A5, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_OK, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_TEARDOWN, 32'hA5A5_A5A5, 32'h0000_0000, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_MISS, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_UPDATE, 32'hFFFF_FFFF, 32'h0000_0008, ST_HANDSHAKING, 1'b0},
			WANT_MODEL, '0},
		// a cap of zero refuses any fresh slot, but not a present peer
		'{ROW_CAP, 5'd0, '0, WANT_MODEL, '0},
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'h5A5A_5A5A, 32'h0000_0002, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_CAP, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'hFFFF_FFFF, 32'h0000_0002, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_OK, 4'd1, ST_HANDSHAKING, 1'b0}},
		'{ROW_CAP, 5'd31, '0, WANT_MODEL, '0},
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'h5A5A_5A5A, 32'h0000_0003, ST_NONE, 1'b0},
			WANT_MODEL, '0},
		// two slots handshaking and a cap of two: refuse
		'{ROW_CAP, 5'd2, '0, WANT_MODEL, '0},
		'{ROW_REQ, NO_CAP, '{FN_ALLOC, 32'h1111_1111, 32'h0000_0004, ST_NONE, 1'b0},
			WANT_TYPED, '{STS_CAP, 4'd0, ST_NONE, 1'b0}},
		'{ROW_REQ, NO_CAP, '{FN_LOOKUP, 32'h5A5A_5A5A, 32'hFFFF_FFFF, ST_OVER, 1'b1},
			WANT_MODEL, '0},
		'{ROW_CAP, 5'd16, '0, WANT_MODEL, '0}
	};

	logic [CAP_W-1:0] phase_caps [8] = '{5'd8, 5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd4};

	session_slot_table_lru uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.remote_addr  (remote_addr),
		.now_ms       (now_ms),
		.new_state    (new_state),
		.new_verified (new_verified),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.slot_state   (slot_state),
		.slot_verified(slot_verified)
	);

	always #5 clk = ~clk;

	// Result of one slot as the block reports it after a successful operation.
	function automatic slot_res_t slot_view(input int idx);
		slot_res_t res;
		res.status = STS_OK;
		res.slot   = idx[SLOT_W-1:0];
		res.state  = tbl_state[idx];
		res.ver    = tbl_ver[idx];
		return res;
	endfunction

	// Apply one request to the bench table and return the result it must produce.
	function automatic slot_res_t slot_table_outcome(input slot_req_t r);
		int          hit;
		int          target;
		int          k;
		int unsigned handshaking;
		slot_res_t   res;
		hit = -1;
		target = -1;
		handshaking = 0;
		res = '0;
		for (k = 0; k < NSLOT; k++) begin
			if (hit < 0 && tbl_state[k] != ST_NONE && tbl_peer[k] == r.addr)
				hit = k;
		end
		case (r.func)
			FN_LOOKUP: begin
				if (hit < 0) res.status = STS_MISS;
				else res = slot_view(hit);
			end
			FN_TEARDOWN: begin
				if (hit < 0) begin
					res.status = STS_MISS;
				end else begin
					tbl_state[hit] = ST_NONE;
					tbl_ver[hit]   = 1'b0;
					res = slot_view(hit);
				end
			end
			FN_UPDATE: begin
				if (hit < 0) begin
					res.status = STS_MISS;
				end else begin
					tbl_state[hit] = (r.nst > ST_ACTIVE) ? ST_ACTIVE : r.nst;
					tbl_ver[hit]   = r.nver;
					tbl_seen[hit]  = r.now;
					res = slot_view(hit);
				end
			end
			default: begin
				if (hit >= 0) begin
					res = slot_view(hit);
				end else begin
					for (k = 0; k < NSLOT; k++)
						if (tbl_state[k] == ST_HANDSHAKING) handshaking++;
					if (handshaking >= cap_model) begin
						res.status = STS_CAP;
					end else begin
						// lowest free slot first
						for (k = 0; k < NSLOT; k++)
							if (target < 0 && tbl_state[k] == ST_NONE) target = k;
						// else the oldest slot that is not verified-active, lower index on a tie
						if (target < 0) begin
							for (k = 0; k < NSLOT; k++) begin
								if (!(tbl_state[k] == ST_ACTIVE && tbl_ver[k]) &&
										(target < 0 || tbl_seen[k] < tbl_seen[target]))
									target = k;
							end
						end
						if (target < 0) begin
							res.status = STS_FULL;
						end else begin
							tbl_state[target] = ST_HANDSHAKING;
							tbl_ver[target]   = 1'b0;
							tbl_peer[target]  = r.addr;
							tbl_seen[target]  = r.now;
							res = slot_view(target);
						end
					end
				end
			end
		endcase
		return res;
	endfunction

	// Time base: mostly creeping forward, sometimes standing still (ties), sometimes a jump.
	function automatic logic [31:0] next_stamp();
		case ($urandom_range(0, 19))
			0: clock_ms = $urandom;
			1, 2: ;
			default: clock_ms = clock_ms + $urandom_range(1, 40);
		endcase
		return clock_ms;
	endfunction

	function automatic slot_req_t roll_request();
		slot_req_t r;
		int        pick;
		pick = $urandom_range(0, 99);
		r.func = (pick < 35) ? FN_ALLOC : (pick < 60) ? FN_UPDATE :
			(pick < 80) ? FN_LOOKUP : FN_TEARDOWN;
		r.addr = ($urandom_range(0, 11) == 0) ? $urandom : peer_pool[$urandom_range(0, POOL_N - 1)];
		r.now  = next_stamp();
		r.nst  = 2'($urandom_range(0, 3));
		r.nver = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("cycle %0d: %s", cyc, what);
		mismatch_cnt++;
	endtask

	// Sender pacing: bursts of random length, each preceded by a random gap outside steady phases.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady != 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	// Present one request, hold it until the transfer, then record what it owes.
	task automatic issue(input slot_req_t r, input want_src_t src, input slot_res_t want);
		slot_res_t guess;
		@(negedge clk);
		in_valid     <= 1'b1;
		func         <= r.func;
		remote_addr  <= r.addr;
		now_ms       <= r.now;
		new_state    <= r.nst;
		new_verified <= r.nver;
		do @(posedge clk); while (!in_ready);
		guess = slot_table_outcome(r);
		outcome_due.push_back((src == WANT_TYPED) ? want : guess);
	endtask

	task automatic send(input slot_req_t r);
		pace();
		issue(r, WANT_MODEL, '0);
		random_sent++;
	endtask

	// Drop valid and hold off until every owed result has been taken.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outcome_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_cap(input logic [CAP_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cap_model = value;
	endtask

	// Fill the table with verified-active peers until alloc runs out of victims,
	// then unlock or tear down part of them again.
	task automatic lock_sweep();
		logic [31:0] held [NSLOT];
		slot_req_t   r;
		int          k;
		for (k = 0; k < NSLOT; k++) begin
			held[k] = $urandom;
			r = '{FN_ALLOC, held[k], next_stamp(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))};
			send(r);
			r.func = FN_UPDATE;
			r.nst  = $urandom_range(0, 1) ? ST_ACTIVE : ST_OVER;
			r.nver = 1'b1;
			r.now  = next_stamp();
			send(r);
		end
		for (k = 0; k < 3; k++)
			send('{FN_ALLOC, $urandom, next_stamp(), ST_NONE, 1'b0});
		for (k = 0; k < NSLOT; k++) begin
			case ($urandom_range(0, 2))
				0: send('{FN_TEARDOWN, held[k], next_stamp(), ST_NONE, 1'b0});
				1: send('{FN_UPDATE, held[k], next_stamp(), ST_HANDSHAKING, 1'b0});
				default: ;
			endcase
		end
	endtask

	// Receiver: a stall pattern chosen by bits 9:8 of the cycle count.
	always @(negedge clk) begin
		case (rx_mode_t'((cyc >> 8) & 3))
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_BEAT: out_ready <= ((cyc % 4) == 0);
			default: begin
				// long stalls, then one ready cycle
				if (rx_hold == 0) begin
					out_ready <= 1'b1;
					rx_hold = $urandom_range(0, 15);
				end else begin
					out_ready <= 1'b0;
					rx_hold--;
				end
			end
		endcase
	end

	// Compare each result transfer with the oldest owed result.
	always @(posedge clk) begin : check_results
		slot_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_due.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d/%0d with nothing outstanding",
					status, slot, slot_state, slot_verified));
			end else begin
				want = outcome_due.pop_front();
				if (status !== want.status || slot !== want.slot ||
						slot_state !== want.state || slot_verified !== want.ver)
					report_mismatch($sformatf(
						"status/slot/state/verified got %0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d",
						status, slot, slot_state, slot_verified,
						want.status, want.slot, want.state, want.ver));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int               n;
		int               ph;
		int               quota;
		int               start;
		logic [CAP_W-1:0] cap_pick;
		for (n = 0; n < NSLOT; n++) begin
			tbl_state[n] = ST_NONE;
			tbl_ver[n]   = 1'b0;
			tbl_peer[n]  = '0;
			tbl_seen[n]  = '0;
		end
		peer_pool[0] = 32'h0000_0000;
		peer_pool[1] = 32'hFFFF_FFFF;
		for (n = 2; n < POOL_N; n++) peer_pool[n] = $urandom;

		// hold reset, then release it on a falling edge, between rising edges
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed script
		for (n = 0; n < NROWS; n++) begin
			if (script[n].kind == ROW_CAP) begin
				write_cap(script[n].cap);
			end else begin
				pace();
				issue(script[n].req, script[n].src, script[n].want);
			end
		end

		// random phases, each under its own cap; odd phases send back to back
		ph = 0;
		while (random_sent < RANDOM_ITEMS) begin
			cap_pick = (ph < 8) ? phase_caps[ph] : CAP_W'($urandom_range(0, 31));
			write_cap(cap_pick);
			steady = ph % 2;
			burst_left = 0;
			for (n = 2; n < POOL_N; n++)
				if ($urandom_range(0, 2) == 0) peer_pool[n] = $urandom;
			quota = (cap_pick == 0) ? 40 : 160;
			start = random_sent;
			while (random_sent - start < quota) begin
				if ($urandom_range(0, 11) == 0) lock_sweep();
				else send(roll_request());
				// now and then let the block drain completely before going on
				if ($urandom_range(0, 149) == 0) wait_drained();
			end
			ph++;
		end

		// drain, then allow for anything stray coming out late
		wait_drained();
		repeat (NSLOT + 8) @(posedge clk);
		if (mismatch_cnt == 0 && outcome_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ session_slot_table_lru.f @@
+incdir+sv
sv/ssl_pkg.sv
sv/ssl_cell.sv
sv/ssl_ctrl.sv
sv/session_slot_table_lru.sv
bench/session_slot_table_lru_test.sv
